@@ sv/acache_pkg.sv @@
// Shared constants, codes and helpers for the associative cache.
`default_nettype none
package acache_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int CTR_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int ADDR_W  = 2;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  localparam logic POL_LRU = 1'b0;
  localparam logic POL_LFU = 1'b1;

  // saturating increment of a 32-bit counter
  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (v == {CTR_W{1'b1}}) ? v : v + CTR_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ sv/assoc_cache_lru_lfu_top.sv @@
// Fully associative key/value cache with LRU or LFU replacement.
//
//  port group    | direction | transfer taken when
//  --------------+-----------+---------------------------------------------
//  request       | in        | start high and busy low at a rising edge
//  result        | out       | done high for one cycle; cannot be refused
//  apb config    | in/out    | psel, penable, pwrite high (pready tied high)
//
//  A lookup, or an insert once the miss count has reached ENTRIES, scans all
//  ENTRIES entries through one shared compare unit, one entry per cycle from
//  the entry stores. An insert while the miss count is below ENTRIES skips
//  the scan and goes straight to the final step.
//  Reset (rst, synchronous) clears the valid bits, the stamp/frequency
//  written flags, the counters and the policy; key and value stores are
//  not cleared, so no clearing pass is needed. busy is high from the
//  accepting edge until done; the result side never stalls.
`default_nettype none
module assoc_cache_lru_lfu_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              action,
  input  wire logic [acache_pkg::KEY_W-1:0]      lookup_key,
  input  wire logic signed [acache_pkg::VAL_W-1:0] store_value,
  // result
  output logic                                   done,
  output logic                                   hit,
  output logic signed [acache_pkg::VAL_W-1:0]    found_value,
  output logic [acache_pkg::SLOT_W-1:0]          slot,
  output logic [acache_pkg::CTR_W-1:0]           hit_total,
  output logic [acache_pkg::CTR_W-1:0]           miss_total,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [acache_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;

  // configuration: a single register, the low address bits are byte offset
  logic policy;

  assign pready = 1'b1;
  assign prdata = {31'b0, policy};

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= acache_pkg::POL_LRU;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] == paddr)) begin
      policy <= pwdata[0];
    end
  end

  // entry stores, one read port (scan index) and one write port (slot)
  logic [acache_pkg::KEY_W-1:0] key_mem   [acache_pkg::ENTRIES];
  logic [acache_pkg::VAL_W-1:0] val_mem   [acache_pkg::ENTRIES];
  logic [acache_pkg::CTR_W-1:0] stamp_mem [acache_pkg::ENTRIES];
  logic [acache_pkg::CTR_W-1:0] freq_mem  [acache_pkg::ENTRIES];

  // per-entry flags: entry valid, and stamp/frequency written since reset
  logic [acache_pkg::ENTRIES-1:0] valid;
  logic [acache_pkg::ENTRIES-1:0] stamp_ok;
  logic [acache_pkg::ENTRIES-1:0] freq_ok;

  // request held for the whole operation
  logic                         req_act;
  logic [acache_pkg::KEY_W-1:0] req_key;
  logic [acache_pkg::VAL_W-1:0] req_val;

  // sequencer and scan pipeline
  logic [acache_pkg::CNT_W-1:0] cnt;
  logic [acache_pkg::IDX_W-1:0] rd_addr;
  logic                         rd_vld;
  logic [acache_pkg::IDX_W-1:0] rd_idx;
  logic [acache_pkg::KEY_W-1:0] rd_key;
  logic [acache_pkg::VAL_W-1:0] rd_val;
  logic [acache_pkg::CTR_W-1:0] rd_stamp;
  logic [acache_pkg::CTR_W-1:0] rd_freq;

  // scan results
  logic                         found;
  logic [acache_pkg::IDX_W-1:0] slot_q;
  logic [acache_pkg::VAL_W-1:0] val_cap;
  logic [acache_pkg::CTR_W-1:0] freq_cap;
  logic [acache_pkg::CTR_W-1:0] best;

  // global counters
  logic [acache_pkg::CTR_W-1:0] stamp_ctr;
  logic [acache_pkg::CTR_W-1:0] hit_ctr;
  logic [acache_pkg::CTR_W-1:0] miss_ctr;

  logic accept;
  logic is_lookup;
  logic scan_end;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign is_lookup = (req_act == acache_pkg::ACT_LOOKUP);
  assign scan_end  = (cnt == acache_pkg::CNT_W'(acache_pkg::ENTRIES));
  assign rd_addr   = cnt[acache_pkg::IDX_W-1:0];

  // stamp/frequency of the entry being examined; never written reads zero
  logic [acache_pkg::CTR_W-1:0] stamp_eff;
  logic [acache_pkg::CTR_W-1:0] freq_eff;
  logic [acache_pkg::CTR_W-1:0] metric;

  assign stamp_eff = stamp_ok[rd_idx] ? rd_stamp : '0;
  assign freq_eff  = freq_ok[rd_idx]  ? rd_freq  : '0;
  assign metric    = (policy == acache_pkg::POL_LRU) ? stamp_eff : freq_eff;

  // the shared compare unit: key match on lookup, less-than on victim search
  logic [acache_pkg::KEY_W-1:0] cmp_a;
  logic [acache_pkg::KEY_W-1:0] cmp_b;
  logic                         cmp_eq;
  logic                         cmp_lt;

  assign cmp_a  = is_lookup ? rd_key  : {{(acache_pkg::KEY_W-acache_pkg::CTR_W){1'b0}}, metric};
  assign cmp_b  = is_lookup ? req_key : {{(acache_pkg::KEY_W-acache_pkg::CTR_W){1'b0}}, best};
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);

  // final-step write controls
  logic                         fin;
  logic                         lk_hit;
  logic                         ins;
  logic [acache_pkg::CTR_W-1:0] stamp_ctr_inc;
  logic                         stamp_we;
  logic [acache_pkg::CTR_W-1:0] stamp_wd;
  logic                         freq_we;
  logic [acache_pkg::CTR_W-1:0] freq_wd;
  logic                         kv_we;

  assign fin           = (state == ST_FIN);
  assign lk_hit        = is_lookup && found;
  assign ins           = !is_lookup;
  assign stamp_ctr_inc = acache_pkg::sat_inc(stamp_ctr);

  always_comb begin
    stamp_we = fin && ((lk_hit && policy == acache_pkg::POL_LRU) ||
                       (ins && (policy == acache_pkg::POL_LRU || !stamp_ok[slot_q])));
    stamp_wd = (policy == acache_pkg::POL_LRU) ? stamp_ctr_inc : '0;
    freq_we  = fin && ((lk_hit && policy == acache_pkg::POL_LFU) ||
                       (ins && (policy == acache_pkg::POL_LFU || !freq_ok[slot_q])));
    if (ins) begin
      freq_wd = (policy == acache_pkg::POL_LFU) ? acache_pkg::CTR_W'(1) : '0;
    end else begin
      freq_wd = acache_pkg::sat_inc(freq_cap);
    end
    kv_we = fin && ins;
  end

  // stores: registered read at the scan index, write at the slot
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_val   <= val_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
    rd_freq  <= freq_mem[rd_addr];
    if (kv_we) begin
      key_mem[slot_q] <= req_key;
      val_mem[slot_q] <= req_val;
    end
    if (stamp_we) begin
      stamp_mem[slot_q] <= stamp_wd;
    end
    if (freq_we) begin
      freq_mem[slot_q] <= freq_wd;
    end
  end

  // request capture and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_act <= action;
      req_key <= lookup_key;
      req_val <= store_value;
    end
    rd_idx <= rd_addr;
    if (accept) begin
      if (action == acache_pkg::ACT_INSERT &&
          miss_ctr < acache_pkg::CTR_W'(acache_pkg::ENTRIES)) begin
        // still filling: the fill slot is the miss count
        slot_q <= miss_ctr[acache_pkg::IDX_W-1:0];
      end else begin
        slot_q <= '0;
      end
    end else if (rd_vld) begin
      if (is_lookup) begin
        if (!found && valid[rd_idx] && cmp_eq) begin
          slot_q   <= rd_idx;
          val_cap  <= rd_val;
          freq_cap <= freq_eff;
        end
      end else if (rd_idx == '0 || cmp_lt) begin
        // strict less-than keeps ties on the lowest index
        slot_q <= rd_idx;
        best   <= metric;
      end
    end
  end

  // sequencer, flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      valid     <= '0;
      stamp_ok  <= '0;
      freq_ok   <= '0;
      stamp_ctr <= '0;
      hit_ctr   <= '0;
      miss_ctr  <= '0;
      done      <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == ST_SCAN) && !scan_end;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            found <= 1'b0;
            if (action == acache_pkg::ACT_INSERT &&
                miss_ctr < acache_pkg::CTR_W'(acache_pkg::ENTRIES)) begin
              state <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld && is_lookup && valid[rd_idx] && cmp_eq) begin
            found <= 1'b1;
          end
          if (scan_end) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt + acache_pkg::CNT_W'(1);
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (ins) begin
            valid[slot_q]    <= 1'b1;
            stamp_ok[slot_q] <= 1'b1;
            freq_ok[slot_q]  <= 1'b1;
            stamp_ctr        <= stamp_ctr_inc;
          end else if (found) begin
            hit_ctr <= acache_pkg::sat_inc(hit_ctr);
            if (policy == acache_pkg::POL_LRU) begin
              stamp_ctr <= stamp_ctr_inc;
            end
          end else begin
            miss_ctr <= acache_pkg::sat_inc(miss_ctr);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result registers; counters are read straight from their registers
  always_ff @(posedge clk) begin
    if (fin) begin
      hit         <= lk_hit;
      found_value <= lk_hit ? val_cap : '0;
      slot        <= acache_pkg::SLOT_W'(slot_q);
    end
  end

  assign hit_total  = hit_ctr;
  assign miss_total = miss_ctr;

`ifndef SYNTHESIS
  // a result only follows the final step
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FIN))
    else $error("result strobe without final step");

  // a reported hit points at a valid entry
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> valid[slot_q])
    else $error("hit on an invalid entry");

  // an insert leaves its slot valid
  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    (fin && ins) |=> valid[$past(slot_q)])
    else $error("inserted entry not valid");

  // one operation never counts both a hit and a miss
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    !((hit_ctr != $past(hit_ctr)) && (miss_ctr != $past(miss_ctr))))
    else $error("hit and miss counted together");
`endif

endmodule
`default_nettype wire
